[hdl/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define CHK_ALWAYS(label, clk, rst, expr) \
   `CHK_PROP(label, clk, rst, (expr))
`else
`define CHK_PROP(label, clk, rst, prop)
`define CHK_ALWAYS(label, clk, rst, expr)
`endif
`endif

[hdl/ffba_pkg.sv]
package ffba_pkg;

   localparam int SIZE_W = 24;
   localparam int POS_W  = 25;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_REBUILD = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NOSPACE = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_BADFREE = 2'd3;

   localparam logic [SIZE_W-1:0] POOL_RESET = 24'h010000;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [SIZE_W-1:0] request_size;
      logic [SIZE_W-1:0] block_offset;
   } ffba_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SIZE_W-1:0] granted_offset;
      logic [SIZE_W-1:0] free_bytes_now;
   } ffba_rsp_type;

   typedef struct packed {
      logic              used;
      logic [SIZE_W-1:0] size;
   } ffba_entry_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_REBUILD, S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR,
      S_SPLIT_HI, S_SPLIT_LO, S_MERGE_RD, S_MERGE_CHK, S_MERGE_END, S_DONE
   } ffba_state_type;

endpackage

[hdl/ffba_table.sv]
// block table ram, one write and one registered read per cycle
module ffba_table
   import ffba_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [AW-1:0]  wr_addr,
   input  ffba_entry_type wr_data,
   input  logic [AW-1:0]  rd_addr,
   output ffba_entry_type rd_data
);

   ffba_entry_type mem [DEPTH];
   ffba_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/first_fit_block_allocator.sv]
// channel   ports                          beat
// req       start, busy, req_payload       one command, taken when start and not busy
// rsp       rsp_valid, rsp_payload         one result, held for a single cycle
// csr       csr_valid, csr_ready, csr_wdata pool size in bytes, always ready
//
// alloc and free walk the block table ram, reading then checking each entry visited
// alloc: scan to the first fit, then shift later entries up and split it, or take it whole
// free: scan up to the match, then a merge pass over all entries and a last write
// pool reset rewrites entry 0; after reset, S_INIT rebuilds entry 0 (busy high)
// results cannot be stalled; busy stays high until the result cycle ends
`include "assert_macros.svh"
module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 8,
   parameter int ADDR_BITS    = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ffba_req_type req_payload,
   output logic         rsp_valid,
   output ffba_rsp_type rsp_payload,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [SIZE_W-1:0] csr_wdata
);

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [CW-1:0]     MAX_CNT = CW'(MAX_BLOCKS);
   localparam logic [SIZE_W-1:0] HDR     = SIZE_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0]  HDR_P   = POS_W'(HEADER_BYTES);
   localparam logic [63:0]       MASK64  = (64'd1 << ADDR_BITS) - 64'd1;
   localparam logic [POS_W-1:0]  ADDR_MASK = MASK64[POS_W-1:0];
   localparam logic [SIZE_W-1:0] RESET_BASE = POOL_RESET - HDR;

   ffba_state_type state_ff, state_in;

   logic [SIZE_W-1:0] pool_ff, pool_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [SIZE_W-1:0] free_ff, free_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [SIZE_W-1:0] reqsz_ff, reqsz_in;
   logic [SIZE_W-1:0] off_ff, off_in;
   logic [CW-1:0]     k_ff, k_in;      // scan index, also matched block
   logic [CW-1:0]     j_ff, j_in;      // shift / merge write index
   logic [CW-1:0]     r_ff, r_in;      // merge read index
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SIZE_W-1:0] rest_ff, rest_in;
   ffba_entry_type    hold_ff, hold_in; // block being merged into
   logic [1:0]        status_ff, status_in;
   logic [SIZE_W-1:0] grant_ff, grant_in;

   logic           wr_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   ffba_entry_type wr_data, q;

   logic [SIZE_W-1:0] rest;
   logic [POS_W-1:0]  pay_pos;
   logic              q_used;
   logic [SIZE_W-1:0] base;

   ffba_table #(.DEPTH(MAX_BLOCKS), .AW(AW)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (q)
   );

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_payload = '{status: status_ff, granted_offset: grant_ff,
                          free_bytes_now: free_ff};

   assign rest    = q.size - reqsz_ff;
   assign pay_pos = (pos_ff + HDR_P) & ADDR_MASK;
   // the block being freed reads as free during the merge pass
   assign q_used  = (r_ff == k_ff) ? 1'b0 : q.used;
   assign base    = (pool_ff >= HDR) ? pool_ff - HDR : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         pool_ff  <= POOL_RESET;
         count_ff <= CW'(1);
         free_ff  <= RESET_BASE;
      end else begin
         state_ff <= state_in;
         pool_ff  <= pool_in;
         count_ff <= count_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      reqsz_ff  <= reqsz_in;
      off_ff    <= off_in;
      k_ff      <= k_in;
      j_ff      <= j_in;
      r_ff      <= r_in;
      pos_ff    <= pos_in;
      rest_ff   <= rest_in;
      hold_ff   <= hold_in;
      status_ff <= status_in;
      grant_ff  <= grant_in;
   end

   always_comb begin
      state_in  = state_ff;
      pool_in   = (csr_valid && csr_ready) ? csr_wdata : pool_ff;
      count_in  = count_ff;
      free_in   = free_ff;
      cmd_in    = cmd_ff;
      reqsz_in  = reqsz_ff;
      off_in    = off_ff;
      k_in      = k_ff;
      j_in      = j_ff;
      r_in      = r_ff;
      pos_in    = pos_ff;
      rest_in   = rest_ff;
      hold_in   = hold_ff;
      status_in = status_ff;
      grant_in  = grant_ff;
      wr_en     = 1'b0;
      wr_addr   = k_ff[AW-1:0];
      wr_data   = q;
      rd_addr   = k_ff[AW-1:0];

      case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '{used: 1'b0, size: RESET_BASE};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd_in    = req_payload.cmd;
               reqsz_in  = req_payload.request_size;
               off_in    = req_payload.block_offset;
               k_in      = '0;
               pos_in    = '0;
               grant_in  = '0;
               status_in = STAT_OK;
               case (req_payload.cmd)
                  CMD_ALLOC: begin
                     if (req_payload.request_size > free_ff) begin
                        status_in = STAT_NOSPACE;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  CMD_FREE:    state_in = S_SCAN_RD;
                  CMD_REBUILD: state_in = S_REBUILD;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_REBUILD: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = '{used: 1'b0, size: base};
            count_in = CW'(1);
            free_in  = base;
            state_in = S_DONE;
         end
         S_SCAN_RD: begin
            rd_addr  = k_ff[AW-1:0];
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (cmd_ff == CMD_ALLOC && !q.used && q.size >= reqsz_ff) begin
               if (rest < HDR) begin
                  // remainder too small for a header: take the block whole
                  wr_en    = 1'b1;
                  wr_data  = '{used: 1'b1, size: q.size};
                  free_in  = free_ff - q.size;
                  grant_in = pay_pos[SIZE_W-1:0];
                  state_in = S_DONE;
               end else if (count_ff >= MAX_CNT) begin
                  status_in = STAT_FULL;
                  state_in  = S_DONE;
               end else begin
                  rest_in  = rest;
                  grant_in = pay_pos[SIZE_W-1:0];
                  j_in     = count_ff;
                  state_in = (count_ff > k_ff + CW'(1)) ? S_SHIFT_RD : S_SPLIT_HI;
               end
            end else if (cmd_ff == CMD_FREE &&
                         pay_pos == ({1'b0, off_ff} & ADDR_MASK)) begin
               if (!q.used) begin
                  status_in = STAT_BADFREE;
                  state_in  = S_DONE;
               end else begin
                  free_in  = free_ff + q.size;
                  r_in     = '0;
                  j_in     = '0;
                  state_in = S_MERGE_RD;
               end
            end else begin
               pos_in = pos_ff + HDR_P + {1'b0, q.size};
               k_in   = k_ff + CW'(1);
               if (k_ff + CW'(1) == count_ff) begin
                  status_in = (cmd_ff == CMD_ALLOC) ? STAT_NOSPACE : STAT_BADFREE;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SHIFT_RD: begin
            rd_addr  = AW'(j_ff - CW'(1));
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff[AW-1:0];
            wr_data  = q;
            j_in     = j_ff - CW'(1);
            state_in = (j_ff - CW'(1) > k_ff + CW'(1)) ? S_SHIFT_RD : S_SPLIT_HI;
         end
         S_SPLIT_HI: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(k_ff + CW'(1));
            wr_data  = '{used: 1'b0, size: rest_ff - HDR};
            state_in = S_SPLIT_LO;
         end
         S_SPLIT_LO: begin
            wr_en    = 1'b1;
            wr_data  = '{used: 1'b1, size: reqsz_ff};
            count_in = count_ff + CW'(1);
            free_in  = free_ff - HDR - reqsz_ff;
            state_in = S_DONE;
         end
         S_MERGE_RD: begin
            rd_addr  = r_ff[AW-1:0];
            state_in = S_MERGE_CHK;
         end
         S_MERGE_CHK: begin
            // j counts blocks kept so far, hold is block j-1
            if (j_ff != '0 && !hold_ff.used && !q_used) begin
               hold_in = '{used: 1'b0, size: hold_ff.size + HDR + q.size};
               free_in = free_ff + HDR;
            end else begin
               wr_en   = (j_ff != '0);
               wr_addr = AW'(j_ff - CW'(1));
               wr_data = hold_ff;
               hold_in = '{used: q_used, size: q.size};
               j_in    = j_ff + CW'(1);
            end
            r_in     = r_ff + CW'(1);
            state_in = (r_ff + CW'(1) == count_ff) ? S_MERGE_END : S_MERGE_RD;
         end
         S_MERGE_END: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(j_ff - CW'(1));
            wr_data  = hold_ff;
            count_in = j_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `CHK_PROP(a_start_busy, clock, reset, (start && !busy) |=> busy)
   `CHK_PROP(a_one_strobe, clock, reset, rsp_valid |=> !rsp_valid)
   `CHK_ALWAYS(a_count_range, clock, reset, count_ff != '0 && count_ff <= MAX_CNT)
   `CHK_PROP(a_fail_no_grant, clock, reset,
             (rsp_valid && rsp_payload.status != STAT_OK) |-> rsp_payload.granted_offset == '0)

endmodule

[dv/first_fit_block_allocator_tb.sv]
`timescale 1ns / 100ps
module first_fit_block_allocator_tb
   import ffba_pkg::*;
();

   localparam int MAX_BLOCKS   = 64;
   localparam int HEADER_BYTES = 8;
   localparam logic [1:0] CMD_SPARE = 2'd3;   // undecoded opcode, must be a no-op
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 400;         // worst command walks the table twice

   // model of the block: block table, free byte count and pending results
   class alloc_scoreboard;
      longint     pool_size;
      bit         used [MAX_BLOCKS];
      longint     size [MAX_BLOCKS];
      int         count;
      longint     free_cnt;
      ffba_rsp_type pending [$];
      logic [SIZE_W-1:0] live [$];    // offsets currently held by allocations
      int         errors;
      int         n_checked;
      int         n_stat [4];

      function new();
         pool_size = POOL_RESET;
         errors = 0;
         n_checked = 0;
         foreach (n_stat[i]) n_stat[i] = 0;
         rebuild_pool();
      endfunction

      function void rebuild_pool();
         foreach (used[i]) begin
            used[i] = 0;
            size[i] = 0;
         end
         size[0] = (pool_size >= HEADER_BYTES) ? pool_size - HEADER_BYTES : 0;
         count = 1;
         free_cnt = size[0];
         live.delete();
      endfunction

      function void coalesce();
         int w;
         w = 0;
         for (int r = 0; r < count; r++) begin
            if (w > 0 && !used[w-1] && !used[r]) begin
               size[w-1] += HEADER_BYTES + size[r];
               free_cnt += HEADER_BYTES;
            end else begin
               used[w] = used[r];
               size[w] = size[r];
               w++;
            end
         end
         count = w;
      endfunction

      function logic [1:0] take_block(longint req, output logic [SIZE_W-1:0] grant);
         longint pos;
         longint rest;
         pos = 0;
         grant = '0;
         if (req > free_cnt) return STAT_NOSPACE;
         for (int k = 0; k < count; k++) begin
            if (!used[k] && size[k] >= req) begin
               rest = size[k] - req;
               if (rest < HEADER_BYTES) begin
                  used[k] = 1;
                  free_cnt -= size[k];
               end else begin
                  if (count >= MAX_BLOCKS) return STAT_FULL;
                  for (int j = count; j > k + 1; j--) begin
                     used[j] = used[j-1];
                     size[j] = size[j-1];
                  end
                  used[k+1] = 0;
                  size[k+1] = rest - HEADER_BYTES;
                  used[k] = 1;
                  size[k] = req;
                  count++;
                  free_cnt -= HEADER_BYTES + req;
               end
               grant = SIZE_W'(pos + HEADER_BYTES);
               return STAT_OK;
            end
            pos += HEADER_BYTES + size[k];
         end
         return STAT_NOSPACE;
      endfunction

      function logic [1:0] release_block(logic [SIZE_W-1:0] off);
         longint pos;
         pos = 0;
         for (int k = 0; k < count; k++) begin
            if (SIZE_W'(pos + HEADER_BYTES) == off) begin
               if (!used[k]) return STAT_BADFREE;
               used[k] = 0;
               free_cnt += size[k];
               coalesce();
               return STAT_OK;
            end
            pos += HEADER_BYTES + size[k];
         end
         return STAT_BADFREE;
      endfunction

      // accepted command beat: update the model and queue its result
      function void note_command(ffba_req_type r);
         ffba_rsp_type e;
         logic [SIZE_W-1:0] g;
         e = '0;
         g = '0;
         case (r.cmd)
            CMD_ALLOC: begin
               e.status = take_block(r.request_size, g);
               if (e.status == STAT_OK) begin
                  e.granted_offset = g;
                  live.push_back(g);
               end
            end
            CMD_FREE: begin
               e.status = release_block(r.block_offset);
               if (e.status == STAT_OK)
                  foreach (live[i])
                     if (live[i] == r.block_offset) begin
                        live.delete(i);
                        break;
                     end
            end
            CMD_REBUILD: rebuild_pool();
            default: ;
         endcase
         e.free_bytes_now = SIZE_W'(free_cnt);
         pending.push_back(e);
      endfunction

      // result beat: compare with the oldest pending result
      function void check_result(ffba_rsp_type a);
         ffba_rsp_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: result with nothing pending, expected none, actual %p", $time, a);
            return;
         end
         e = pending.pop_front();
         n_checked++;
         n_stat[e.status]++;
         if (a.status !== e.status || a.granted_offset !== e.granted_offset ||
             a.free_bytes_now !== e.free_bytes_now) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, e, a);
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   ffba_req_type req_payload;
   logic         rsp_valid;
   ffba_rsp_type rsp_payload;
   logic         csr_valid;
   logic         csr_ready;
   logic [SIZE_W-1:0] csr_wdata;

   alloc_scoreboard sb;
   longint cycles;
   bit     idle_on;
   int     n_cfg;

   first_fit_block_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial sb = new();

   // monitor: every beat is sampled on the rising edge, before the rtl updates
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("first_fit_block_allocator_tb failed");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_payload);
         if (start && !busy) sb.note_command(req_payload);
         if (csr_valid && csr_ready) begin
            sb.pool_size = csr_wdata;   // takes effect at the next pool reset
            n_cfg++;
         end
      end
   end

   // one command beat, with an optional idle burst in front of it
   task automatic send_cmd(logic [1:0] c, logic [SIZE_W-1:0] rs, logic [SIZE_W-1:0] off);
      ffba_req_type r;
      r.cmd = c;
      r.request_size = rs;
      r.block_offset = off;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0 || busy) @(posedge clock);
   endtask

   // pool size change: only with the block idle, then rebuild the pool
   task automatic set_pool(logic [SIZE_W-1:0] bytes);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= bytes;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      send_cmd(CMD_REBUILD, SIZE_W'($urandom), SIZE_W'($urandom));
   endtask

   // mostly well-formed alloc/free traffic against the live set, some noise
   task automatic random_traffic(int n, longint pool);
      int sel;
      logic [SIZE_W-1:0] rs;
      logic [SIZE_W-1:0] off;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         rs = SIZE_W'($urandom);
         off = SIZE_W'($urandom);
         if (sel < 55) begin
            sel = $urandom_range(0, 99);
            if (sel < 85) rs = SIZE_W'($urandom_range(0, 48));
            else if (sel < 95) rs = SIZE_W'($urandom_range(0, int'(pool)));
            send_cmd(CMD_ALLOC, rs, off);
         end else if (sel < 93) begin
            sel = $urandom_range(0, 99);
            if (sel < 80 && sb.live.size() > 0)
               off = sb.live[$urandom_range(0, sb.live.size() - 1)];
            else if (sel < 90)
               off = SIZE_W'(HEADER_BYTES * $urandom_range(1, 40));   // often a double free
            send_cmd(CMD_FREE, rs, off);
         end else if (sel < 96) begin
            send_cmd(CMD_SPARE, rs, off);
         end else begin
            send_cmd(CMD_REBUILD, rs, off);
         end
      end
   endtask

   longint pools [7];

   initial begin
      cycles = 0;
      n_cfg = 0;
      idle_on = 1;
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset pool of 65536, extremes and special cases
      send_cmd(CMD_ALLOC, 24'hFFFFFF, '0);        // above free count
      send_cmd(CMD_ALLOC, 24'd0, '0);             // zero payload block
      send_cmd(CMD_ALLOC, 24'd100, '0);
      send_cmd(CMD_FREE, '0, 24'hFFFFFF);         // offset matching nothing
      send_cmd(CMD_FREE, '0, 24'd8);
      send_cmd(CMD_FREE, '0, 24'd8);              // double free
      send_cmd(CMD_SPARE, 24'hFFFFFF, 24'hFFFFFF);
      send_cmd(CMD_ALLOC, 24'd65520, '0);         // above free count
      send_cmd(CMD_REBUILD, '0, '0);
      send_cmd(CMD_ALLOC, 24'd65525, '0);         // remainder below a header, no split
      send_cmd(CMD_ALLOC, 24'd0, '0);             // nothing left
      send_cmd(CMD_FREE, '0, 24'd8);
      send_cmd(CMD_ALLOC, 24'd65528, '0);         // exact fit
      send_cmd(CMD_FREE, '0, 24'd8);
      // hole too small for a later request while total free is enough
      send_cmd(CMD_ALLOC, 24'd16, '0);
      send_cmd(CMD_ALLOC, 24'd65480, '0);
      send_cmd(CMD_FREE, '0, 24'd8);
      send_cmd(CMD_ALLOC, 24'd30, '0);
      send_cmd(CMD_REBUILD, '0, '0);

      // phases across pool sizes, extremes included; last one without idling
      pools[0] = 16;
      pools[1] = 24'hFFFFFF;
      pools[2] = 512;
      pools[3] = 2048;
      pools[4] = $urandom_range(16, 4096);
      pools[5] = 1024;
      pools[6] = 65536;
      foreach (pools[p]) begin
         if (p == 6) idle_on = 0;
         set_pool(SIZE_W'(pools[p]));
         random_traffic(95, pools[p]);
         if (p == 3) wait_drained();             // hold off until all results are in
         random_traffic(95, pools[p]);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d results over %0d pool sizes: ok %0d, no space %0d",
               sb.n_checked, n_cfg, sb.n_stat[STAT_OK], sb.n_stat[STAT_NOSPACE]);
      $display("table full %0d, bad free %0d, mismatches %0d",
               sb.n_stat[STAT_FULL], sb.n_stat[STAT_BADFREE], sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("first_fit_block_allocator_tb passed");
      else
         $display("first_fit_block_allocator_tb failed");
      $finish;
   end

endmodule

[first_fit_block_allocator.f]
+incdir+hdl
hdl/ffba_pkg.sv
hdl/ffba_table.sv
hdl/first_fit_block_allocator.sv
dv/first_fit_block_allocator_tb.sv
